>>> rtl/rotation_floor_calibrator_macros.svh
// Assertion macros for the rotation floor calibrator checker.
// Needs clk_i and rst_ni in the scope of each use.
`ifndef ROTATION_FLOOR_CALIBRATOR_MACROS_SVH
`define ROTATION_FLOOR_CALIBRATOR_MACROS_SVH

// same-cycle implication, off during reset
`define RFC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rfc assertion failed");

// next-cycle implication, off during reset
`define RFC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rfc assertion failed");

`endif

>>> rtl/rfc_pkg.sv
// Shared types and constants of the rotation floor calibrator.
// No dependencies.
package rfc_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROT_TOL   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FLOOR_TOL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CONFIRM   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ROTATIONS = 2'd3;

  typedef enum logic [1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_START  = 2'd1,
    CMD_STOP   = 2'd2
  } cmd_e;

  typedef struct packed {
    logic [11:0] rot_tol;
    logic [11:0] floor_tol;
    logic [7:0]  confirm;
    logic [3:0]  needed;
  } cfg_t;

  typedef struct packed {
    logic       complete;
    logic       floor_valid;
    logic       at_floor;
    logic [3:0] rounds;
    logic       calibrating;
    logic [1:0] phase;
  } flags_t;

endpackage

>>> rtl/rfc_if.sv
// Channel interfaces of the rotation floor calibrator: input words,
// result words and configuration writes. Uses rfc_pkg.
interface rfc_in_if #(parameter int DIST_WIDTH = 16);
  logic                         valid;
  logic                         ready;
  logic [1:0]                   command;
  logic signed [DIST_WIDTH-1:0] distance;

  modport source (output valid, command, distance, input ready);
  modport sink   (input valid, command, distance, output ready);
endinterface

interface rfc_out_if #(parameter int DIST_WIDTH = 16);
  logic                  valid;
  logic                  ready;
  logic                  complete;
  logic [DIST_WIDTH-2:0] floor_level_out;
  logic                  floor_valid_out;
  logic                  at_floor;
  logic [3:0]            rounds_done;
  logic                  calibrating;
  logic [1:0]            phase_out;

  modport source (output valid, complete, floor_level_out, floor_valid_out, at_floor,
                  rounds_done, calibrating, phase_out, input ready);
  modport sink   (input valid, complete, floor_level_out, floor_valid_out, at_floor,
                  rounds_done, calibrating, phase_out, output ready);
endinterface

interface rfc_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [rfc_pkg::CFG_IDX_W-1:0]  index;
  logic [rfc_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/rfc_core.sv
// Calibration state and per-word update: running minimum, valley/peak
// rotation detector, floor latch and at-floor test. Uses rfc_pkg.
module rfc_core #(
  parameter int DIST_WIDTH = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         fire_i,
  input  logic [1:0]                   cmd_i,
  input  logic signed [DIST_WIDTH-1:0] dist_i,
  input  rfc_pkg::cfg_t                cfg_i,
  output logic [DIST_WIDTH-2:0]        floor_lvl_o,
  output rfc_pkg::flags_t              flags_o
);

  localparam int VW = DIST_WIDTH - 1;
  // sum width for value plus a 12-bit tolerance
  localparam int SW = ((VW > 12) ? VW : 12) + 1;

  typedef enum logic [1:0] {
    PH_INIT   = 2'd0,
    PH_VALLEY = 2'd1,
    PH_PEAK   = 2'd2,
    PH_DONE   = 2'd3
  } phase_e;

  function automatic logic [7:0] sat_inc(input logic [7:0] c);
    return (c == 8'hFF) ? c : c + 8'd1;
  endfunction

  logic          running_q, running_d;
  phase_e        phase_q, phase_d;
  logic [VW-1:0] omin_q, omin_d;
  logic [VW-1:0] valley_q, valley_d;
  logic [VW-1:0] peak_q, peak_d;
  logic [7:0]    vhold_q, vhold_d;
  logic [7:0]    phold_q, phold_d;
  logic [3:0]    rot_q, rot_d;
  logic [VW-1:0] floor_q, floor_d;
  logic          floor_ok_q, floor_ok_d;

  logic          d_ok;
  logic [VW-1:0] d;
  logic [VW-1:0] omin_min;
  logic [SW-1:0] d_ext, rtol_ext, ftol_ext;
  logic          near_valley, near_peak;
  logic [3:0]    rot_inc;
  logic          done;
  logic          at;

  assign d_ok     = !dist_i[DIST_WIDTH-1];
  assign d        = dist_i[VW-1:0];
  assign omin_min = (d < omin_q) ? d : omin_q;
  assign d_ext    = SW'(d);
  assign rtol_ext = SW'(cfg_i.rot_tol);
  assign ftol_ext = SW'(cfg_i.floor_tol);
  // peak band tested as d + tol >= peak so nothing goes negative
  assign near_valley = d_ext <= SW'(valley_q) + rtol_ext;
  assign near_peak   = d_ext + rtol_ext >= SW'(peak_q);
  assign rot_inc     = (rot_q != 4'hF) ? rot_q + 4'd1 : rot_q;

  always_comb begin
    running_d  = running_q;
    phase_d    = phase_q;
    omin_d     = omin_q;
    valley_d   = valley_q;
    peak_d     = peak_q;
    vhold_d    = vhold_q;
    phold_d    = phold_q;
    rot_d      = rot_q;
    floor_d    = floor_q;
    floor_ok_d = floor_ok_q;
    done       = 1'b0;
    if (fire_i) begin
      unique case (cmd_i)
        rfc_pkg::CMD_SAMPLE: begin
          if (running_q && d_ok) begin
            omin_d = omin_min;
            unique case (phase_q)
              PH_VALLEY: begin
                if (near_valley) begin
                  if (d < valley_q) begin
                    valley_d = d;
                    vhold_d  = 8'd0;
                  end else begin
                    vhold_d = sat_inc(vhold_q);
                  end
                end else if (vhold_q >= cfg_i.confirm) begin
                  phase_d = PH_PEAK;
                  peak_d  = d;
                  phold_d = 8'd0;
                end
              end
              PH_PEAK: begin
                if (near_peak) begin
                  if (d > peak_q) begin
                    peak_d  = d;
                    phold_d = 8'd0;
                  end else begin
                    phold_d = sat_inc(phold_q);
                  end
                end else if (phold_q >= cfg_i.confirm) begin
                  phase_d = PH_DONE;
                end
              end
              PH_DONE: begin
                if (near_valley) begin
                  rot_d    = rot_inc;
                  phase_d  = PH_VALLEY;
                  valley_d = d;
                  vhold_d  = 8'd0;
                  if (rot_inc >= cfg_i.needed) begin
                    floor_d    = omin_min;
                    floor_ok_d = 1'b1;
                    running_d  = 1'b0;
                    done       = 1'b1;
                  end
                end
              end
              default: begin
                phase_d  = PH_VALLEY;
                valley_d = d;
              end
            endcase
          end
        end
        rfc_pkg::CMD_START: begin
          if (d_ok) begin
            running_d = 1'b1;
            rot_d     = 4'd0;
            omin_d    = d;
            phase_d   = PH_VALLEY;
            valley_d  = d;
            peak_d    = d;
            vhold_d   = 8'd0;
            phold_d   = 8'd0;
          end
        end
        rfc_pkg::CMD_STOP: begin
          running_d = 1'b0;
          rot_d     = 4'd0;
          phase_d   = PH_INIT;
        end
        default: ;
      endcase
    end
  end

  assign at = floor_ok_d && d_ok && (d_ext <= SW'(floor_d) + ftol_ext)
              && (SW'(floor_d) <= d_ext + ftol_ext);

  assign floor_lvl_o         = floor_ok_d ? floor_d : '0;
  assign flags_o.complete    = done;
  assign flags_o.floor_valid = floor_ok_d;
  assign flags_o.at_floor    = at;
  assign flags_o.rounds      = rot_d;
  assign flags_o.calibrating = running_d;
  assign flags_o.phase       = phase_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q  <= 1'b0;
      phase_q    <= PH_INIT;
      omin_q     <= {VW{1'b1}};
      valley_q   <= '0;
      peak_q     <= '0;
      vhold_q    <= 8'd0;
      phold_q    <= 8'd0;
      rot_q      <= 4'd0;
      floor_q    <= '0;
      floor_ok_q <= 1'b0;
    end else begin
      running_q  <= running_d;
      phase_q    <= phase_d;
      omin_q     <= omin_d;
      valley_q   <= valley_d;
      peak_q     <= peak_d;
      vhold_q    <= vhold_d;
      phold_q    <= phold_d;
      rot_q      <= rot_d;
      floor_q    <= floor_d;
      floor_ok_q <= floor_ok_d;
    end
  end

endmodule

>>> rtl/rotation_floor_calibrator.sv
// Rotation floor calibrator top level: channel registers, configuration
// registers and the calibration core. Uses rfc_pkg, rfc_if.sv, rfc_core.
//
// Use: in_i takes one word per cycle (command, distance). A start command
// opens a run, samples drive the valley/peak detector, a stop command ends
// the run. Each input word gives exactly one result word on out_o, showing
// the state after that word: completion flag, latched floor, at-floor test,
// rotations counted, run status and detector phase.
// From input acceptance to the result word there is one input register, then
// the state update and result register. Throughput is one word per cycle
// while out_o does not stall, bounded by the state update in the core.
// When out_o stalls, the result register holds and the input register still
// takes one more word; in_i.ready drops once both are full.
// cfg_i writes one of four registers (index 0..3) in any cycle; ready is
// always high. Writes are meant for when no word is in flight.
// Reset empties both registers, restores default configuration and leaves
// the floor invalid.
module rotation_floor_calibrator #(
  parameter int DIST_WIDTH = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  rfc_in_if.sink    in_i,
  rfc_out_if.source out_o,
  rfc_cfg_if.sink   cfg_i
);

  logic                         in_vld_q;
  logic [1:0]                   cmd_q;
  logic signed [DIST_WIDTH-1:0] dist_q;
  logic                         out_vld_q;
  logic [DIST_WIDTH-2:0]        floor_lvl_q;
  rfc_pkg::flags_t              flags_q;
  rfc_pkg::cfg_t                cfg_q;

  logic                         advance;
  logic                         in_take;
  logic [DIST_WIDTH-2:0]        floor_lvl;
  rfc_pkg::flags_t              flags;

  assign advance    = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !in_vld_q || advance;
  assign in_take    = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  rfc_core #(
    .DIST_WIDTH (DIST_WIDTH)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (advance),
    .cmd_i       (cmd_q),
    .dist_i      (dist_q),
    .cfg_i       (cfg_q),
    .floor_lvl_o (floor_lvl),
    .flags_o     (flags)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        in_vld_q <= in_i.valid;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      cmd_q  <= in_i.command;
      dist_q <= in_i.distance;
    end
    if (advance) begin
      floor_lvl_q <= floor_lvl;
      flags_q     <= flags;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rot_tol   <= 12'd50;
      cfg_q.floor_tol <= 12'd20;
      cfg_q.confirm   <= 8'd3;
      cfg_q.needed    <= 4'd2;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        rfc_pkg::CFG_ROT_TOL:   cfg_q.rot_tol   <= cfg_i.data;
        rfc_pkg::CFG_FLOOR_TOL: cfg_q.floor_tol <= cfg_i.data;
        rfc_pkg::CFG_CONFIRM:   cfg_q.confirm   <= cfg_i.data[7:0];
        rfc_pkg::CFG_ROTATIONS: cfg_q.needed    <= cfg_i.data[3:0];
        default: ;
      endcase
    end
  end

  assign out_o.valid           = out_vld_q;
  assign out_o.complete        = flags_q.complete;
  assign out_o.floor_level_out = floor_lvl_q;
  assign out_o.floor_valid_out = flags_q.floor_valid;
  assign out_o.at_floor        = flags_q.at_floor;
  assign out_o.rounds_done     = flags_q.rounds;
  assign out_o.calibrating     = flags_q.calibrating;
  assign out_o.phase_out       = flags_q.phase;

endmodule

>>> rtl/rfc_checker.sv
// Port-level checks for the rotation floor calibrator, bound to the top.
// Uses rotation_floor_calibrator_macros.svh.
`include "rotation_floor_calibrator_macros.svh"

module rfc_checker #(
  parameter int DIST_WIDTH = 16
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic                  complete,
  input logic [DIST_WIDTH-2:0] floor_lvl,
  input logic                  floor_valid,
  input logic                  at_floor,
  input logic [3:0]            rounds_done,
  input logic                  calibrating
);

  logic [DIST_WIDTH+6:0] out_word;

  assign out_word = {complete, floor_lvl, floor_valid, at_floor, rounds_done, calibrating};

  // a stalled result word holds
  `RFC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_word))

  // completion always comes with a latched floor and an ended run
  `RFC_ASSERT_NOW(a_complete_latch, out_valid && complete, floor_valid && !calibrating)

  // without a floor there is no level and nothing is at floor
  `RFC_ASSERT_NOW(a_no_floor, out_valid && !floor_valid, floor_lvl == '0 && !at_floor)

  // an empty result register never blocks the input side
  `RFC_ASSERT_NOW(a_ready_free, !out_valid, in_ready)

endmodule

bind rotation_floor_calibrator rfc_checker #(
  .DIST_WIDTH (DIST_WIDTH)
) u_rfc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready    (in_i.ready),
  .out_valid   (out_o.valid),
  .out_ready   (out_o.ready),
  .complete    (out_o.complete),
  .floor_lvl   (out_o.floor_level_out),
  .floor_valid (out_o.floor_valid_out),
  .at_floor    (out_o.at_floor),
  .rounds_done (out_o.rounds_done),
  .calibrating (out_o.calibrating)
);
